FILE: design/plic_ca_pkg.sv
// Shared constants, kind codes and stage records for the line-cut area pipeline.
`default_nettype none
package plic_ca_pkg;

    localparam int FRAC_BITS = 24;
    localparam int IN_W      = 31;
    localparam int SGN_W     = 32;
    localparam int AREA_W    = 31;
    localparam int PROD_W    = 2 * IN_W;
    localparam int MB_W      = PROD_W - FRAC_BITS;
    localparam int SUM_W     = ((MB_W > SGN_W) ? MB_W : SGN_W) + 2;
    localparam int MUL_W     = 32;
    localparam int NUM_W     = PROD_W + 1;
    localparam int DEN_W     = PROD_W + 1;
    localparam int QW        = AREA_W;
    localparam int REM_W     = DEN_W + QW + 1;

    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    typedef enum logic [2:0] {
        K_ZERO   = 3'd0,
        K_FULL   = 3'd1,
        K_TRI    = 3'd2,
        K_COMP   = 3'd3,
        K_TRAP_Z = 3'd4,
        K_TRAP_X = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [AREA_W-1:0] width;
    } side_t;

    typedef struct packed {
        side_t             side;
        logic [MUL_W-1:0]  op_a;
        logic [MUL_W-1:0]  op_b;
        logic [DEN_W-1:0]  den;
        logic              frac;
    } oper_t;

    typedef struct packed {
        side_t             side;
        logic [REM_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        logic              sat;
    } div_t;

endpackage
`default_nettype wire

FILE: design/plic_ca_setup.sv
// Normal products, case selection and choice of multiplier operands and divisor.
`default_nettype none
module plic_ca_setup (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            in_vld,
    input  wire logic [plic_ca_pkg::IN_W-1:0]    normal_x,
    input  wire logic [plic_ca_pkg::IN_W-1:0]    normal_z,
    input  wire logic [plic_ca_pkg::SGN_W-1:0]   line_offset,
    input  wire logic [plic_ca_pkg::SGN_W-1:0]   cell_width,
    output logic                                 out_vld,
    output plic_ca_pkg::oper_t                   out_op
);

    logic                                v1_reg;
    logic                                pos1_reg;
    logic [plic_ca_pkg::IN_W-1:0]        a1_reg, b1_reg, x1_reg, z1_reg;
    logic [plic_ca_pkg::PROD_W-1:0]      xb1_reg, xz1_reg;
    logic                                v2_reg;
    plic_ca_pkg::oper_t                  op2_reg, op2_next;

    logic [plic_ca_pkg::SUM_W-1:0] mb_e, z_e, a_e, sum, t, lo, hi, a2mb, a2z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos1_reg <= !line_offset[plic_ca_pkg::SGN_W-1] && (line_offset != '0) &&
                        !cell_width[plic_ca_pkg::SGN_W-1] && (cell_width != '0);
            a1_reg   <= line_offset[plic_ca_pkg::IN_W-1:0];
            b1_reg   <= cell_width[plic_ca_pkg::IN_W-1:0];
            x1_reg   <= normal_x;
            z1_reg   <= normal_z;
            xb1_reg  <= plic_ca_pkg::PROD_W'(normal_x) *
                        plic_ca_pkg::PROD_W'(cell_width[plic_ca_pkg::IN_W-1:0]);
            xz1_reg  <= plic_ca_pkg::PROD_W'(normal_x) * plic_ca_pkg::PROD_W'(normal_z);
            op2_reg  <= op2_next;
        end
    end

    always_comb
    begin
        mb_e = plic_ca_pkg::SUM_W'(xb1_reg[plic_ca_pkg::PROD_W-1:plic_ca_pkg::FRAC_BITS]);
        z_e  = plic_ca_pkg::SUM_W'(z1_reg);
        a_e  = plic_ca_pkg::SUM_W'(a1_reg);
        sum  = mb_e + z_e;
        t    = sum - a_e;
        lo   = (mb_e <= z_e) ? mb_e : z_e;
        hi   = (mb_e <= z_e) ? z_e : mb_e;
        a2mb = (a_e << 1) - mb_e;
        a2z  = (a_e << 1) - z_e;

        op2_next.side.width = b1_reg;
        op2_next.op_a       = '0;
        op2_next.op_b       = '0;
        op2_next.den        = '0;
        op2_next.frac       = 1'b1;
        if (!pos1_reg)
        begin
            op2_next.side.kind = plic_ca_pkg::K_ZERO;
        end
        else if (a_e >= sum)
        begin
            op2_next.side.kind = plic_ca_pkg::K_FULL;
        end
        else if (a_e < lo)
        begin
            op2_next.side.kind = plic_ca_pkg::K_TRI;
            op2_next.op_a      = plic_ca_pkg::MUL_W'(a1_reg);
            op2_next.op_b      = plic_ca_pkg::MUL_W'(a1_reg);
            op2_next.den       = {xz1_reg, 1'b0};
        end
        else if (a_e > hi)
        begin
            op2_next.side.kind = plic_ca_pkg::K_COMP;
            op2_next.op_a      = t[plic_ca_pkg::MUL_W-1:0];
            op2_next.op_b      = t[plic_ca_pkg::MUL_W-1:0];
            op2_next.den       = {xz1_reg, 1'b0};
        end
        else if (mb_e <= z_e)
        begin
            // Trapezoid spanning the full width: plain integer quotient.
            op2_next.side.kind = plic_ca_pkg::K_TRAP_Z;
            op2_next.op_a      = plic_ca_pkg::MUL_W'(b1_reg);
            op2_next.op_b      = a2mb[plic_ca_pkg::MUL_W-1:0];
            op2_next.den       = plic_ca_pkg::DEN_W'({z1_reg, 1'b0});
            op2_next.frac      = 1'b0;
        end
        else
        begin
            op2_next.side.kind = plic_ca_pkg::K_TRAP_X;
            op2_next.op_a      = a2z[plic_ca_pkg::MUL_W-1:0];
            op2_next.op_b      = plic_ca_pkg::MUL_W'(1);
            op2_next.den       = plic_ca_pkg::DEN_W'({x1_reg, 1'b0});
        end
    end

    assign out_vld = v2_reg;
    assign out_op  = op2_reg;

endmodule
`default_nettype wire

FILE: design/plic_ca_numer.sv
// Numerator product, fraction scaling and overflow check ahead of the divider.
`default_nettype none
module plic_ca_numer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_vld,
    input  wire plic_ca_pkg::oper_t  in_op,
    output logic                     out_vld,
    output plic_ca_pkg::div_t        out_div
);

    logic                               v3_reg, v4_reg;
    logic [2*plic_ca_pkg::MUL_W-1:0]    prod3_reg;
    logic [plic_ca_pkg::DEN_W-1:0]      den3_reg;
    logic                               frac3_reg;
    plic_ca_pkg::side_t                 side3_reg;
    plic_ca_pkg::div_t                  div4_reg, div4_next;
    logic [plic_ca_pkg::REM_W-1:0]      wide, limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= in_vld;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod3_reg <= (2*plic_ca_pkg::MUL_W)'(in_op.op_a) *
                         (2*plic_ca_pkg::MUL_W)'(in_op.op_b);
            den3_reg  <= in_op.den;
            frac3_reg <= in_op.frac;
            side3_reg <= in_op.side;
            div4_reg  <= div4_next;
        end
    end

    always_comb
    begin
        wide = plic_ca_pkg::REM_W'(prod3_reg[plic_ca_pkg::NUM_W-1:0]);
        if (frac3_reg)
        begin
            wide = wide << plic_ca_pkg::FRAC_BITS;
        end
        limit          = plic_ca_pkg::REM_W'({den3_reg, {plic_ca_pkg::QW{1'b0}}});
        div4_next.side = side3_reg;
        div4_next.rem  = wide;
        div4_next.den  = den3_reg;
        // A quotient that cannot fit the result width, or no divisor at all.
        div4_next.sat  = (den3_reg == '0) || (wide >= limit);
    end

    assign out_vld = v4_reg;
    assign out_div = div4_reg;

endmodule
`default_nettype wire

FILE: design/plic_ca_div.sv
// Restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module plic_ca_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic                             in_vld,
    input  wire plic_ca_pkg::div_t                in_div,
    output logic                                  out_vld,
    output plic_ca_pkg::side_t                    out_side,
    output logic                                  out_sat,
    output logic [plic_ca_pkg::QW-1:0]            out_quo
);

    logic                          vld_reg [plic_ca_pkg::QW];
    plic_ca_pkg::div_t             st_reg  [plic_ca_pkg::QW];
    logic [plic_ca_pkg::QW-1:0]    q_reg   [plic_ca_pkg::QW];

    genvar s;
    generate
        for (s = 0; s < plic_ca_pkg::QW; s++)
        begin : g_stage
            logic                          v_in;
            plic_ca_pkg::div_t             d_in;
            logic [plic_ca_pkg::QW-1:0]    q_in;
            logic [plic_ca_pkg::REM_W-1:0] trial;
            logic                          take;

            if (s == 0)
            begin : g_first
                assign v_in = in_vld;
                assign d_in = in_div;
                assign q_in = '0;
            end
            else
            begin : g_rest
                assign v_in = vld_reg[s-1];
                assign d_in = st_reg[s-1];
                assign q_in = q_reg[s-1];
            end

            assign trial = plic_ca_pkg::REM_W'(d_in.den) << (plic_ca_pkg::QW - 1 - s);
            assign take  = d_in.rem >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[s] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[s].side <= d_in.side;
                    st_reg[s].den  <= d_in.den;
                    st_reg[s].sat  <= d_in.sat;
                    st_reg[s].rem  <= take ? (d_in.rem - trial) : d_in.rem;
                    q_reg[s]       <= {q_in[plic_ca_pkg::QW-2:0], take};
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[plic_ca_pkg::QW-1];
    assign out_side = st_reg[plic_ca_pkg::QW-1].side;
    assign out_sat  = st_reg[plic_ca_pkg::QW-1].sat;
    assign out_quo  = q_reg[plic_ca_pkg::QW-1];

    // After the first step the remainder must sit below the first step's trial divisor.
    a_first_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && !st_reg[0].sat |->
        st_reg[0].rem < (plic_ca_pkg::REM_W'(st_reg[0].den) << (plic_ca_pkg::QW - 1)))
        else $error("divider first step left remainder too large");

    a_last_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[plic_ca_pkg::QW-1] && !st_reg[plic_ca_pkg::QW-1].sat |->
        st_reg[plic_ca_pkg::QW-1].rem < plic_ca_pkg::REM_W'(st_reg[plic_ca_pkg::QW-1].den))
        else $error("divider final remainder not below divisor");

    a_vld_move: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[0] |=> vld_reg[1])
        else $error("valid bit lost between divider stages");

endmodule
`default_nettype wire

FILE: design/plic_cut_area_rect.sv
// Top level of the line-cut area pipeline: handshake, stage chain and output register.
//
//  channel | dir | payload
//  s_*     | in  | tdata: normal_x[30:0] normal_z[61:31] line_offset[93:62] cell_width[125:94]
//  m_*     | out | tdata: cut_area[30:0]; tuser: saturated
//
// Stages: two setup stages, two numerator stages, the 31-stage divider (one quotient bit
// per stage) and the output register; one item is taken every cycle unless the output stalls.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output freezes the whole chain, so nothing is dropped or repeated.
`default_nettype none
module plic_cut_area_rect (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // normal_x, normal_z, line_offset, cell_width, pad
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata,   // cut_area, pad
    output logic [0:0]        m_tuser    // saturated
);

    logic                                adv;
    logic                                su_vld, nu_vld, dv_vld;
    plic_ca_pkg::oper_t                  su_op;
    plic_ca_pkg::div_t                   nu_div;
    plic_ca_pkg::side_t                  dv_side;
    logic                                dv_sat;
    logic [plic_ca_pkg::QW-1:0]          dv_quo, quo;
    logic                                out_vld_reg;
    logic [plic_ca_pkg::AREA_W-1:0]      area_reg, area_next;
    logic                                sat_reg, sat_next;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    plic_ca_setup u_setup (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .in_vld      (s_tvalid),
        .normal_x    (s_tdata[30:0]),
        .normal_z    (s_tdata[61:31]),
        .line_offset (s_tdata[93:62]),
        .cell_width  (s_tdata[125:94]),
        .out_vld     (su_vld),
        .out_op      (su_op)
    );

    plic_ca_numer u_numer (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (su_vld),
        .in_op   (su_op),
        .out_vld (nu_vld),
        .out_div (nu_div)
    );

    plic_ca_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (nu_vld),
        .in_div   (nu_div),
        .out_vld  (dv_vld),
        .out_side (dv_side),
        .out_sat  (dv_sat),
        .out_quo  (dv_quo)
    );

    always_comb
    begin
        quo       = dv_sat ? plic_ca_pkg::AREA_MAX : dv_quo;
        sat_next  = dv_sat;
        area_next = quo;
        case (dv_side.kind)
            plic_ca_pkg::K_ZERO:
            begin
                area_next = '0;
                sat_next  = 1'b0;
            end
            plic_ca_pkg::K_FULL:
            begin
                area_next = dv_side.width;
                sat_next  = 1'b0;
            end
            plic_ca_pkg::K_COMP:
            begin
                // The cell less the corner triangle above the line.
                area_next = (quo >= dv_side.width) ? '0 : (dv_side.width - quo);
            end
            default:
            begin
                area_next = quo;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            area_reg <= area_next;
            sat_reg  <= sat_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, area_reg};
    assign m_tuser  = sat_reg;

endmodule
`default_nettype wire
